FILE: hw/rtl/tpm_pkg.sv
// Shared types and constants for the three-point MPPT tracker.
package tpm_pkg;

    // Input item kinds
    localparam logic KIND_TRACK   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELTA_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_CEILING = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_VOLTAGE_FLOOR   = 2'd3;
    localparam int CFG_DATA_W = 32;

    // Field widths
    localparam int STEP_W  = 21;
    localparam int POWER_W = 31;
    localparam int VOLT_W  = 25;
    localparam int THR_W   = 32;
    localparam int POINT_W = 27;

    // Reset values of the configuration registers
    localparam logic [STEP_W-1:0]       STEP_SIZE_RST = 21'd163840;
    localparam logic signed [THR_W-1:0] THRESHOLD_RST = 32'sd0;
    localparam logic [VOLT_W-1:0]       CEILING_RST   = 25'd27852800;
    localparam logic [VOLT_W-1:0]       FLOOR_RST     = 25'd20807680;

    // Warm-up gain: 0.98 in Q15
    localparam int GAIN_W = 15;
    localparam logic [GAIN_W-1:0] GAIN_098_Q15 = 15'd32112;

    typedef struct packed {
        logic              kind;
        logic [POWER_W-1:0] pv_power;
        logic [VOLT_W-1:0]  pv_voltage;
    } in_item_t;

    typedef struct packed {
        logic [VOLT_W-1:0] voltage_reference;
        logic              warming_up;
    } out_item_t;

    typedef struct packed {
        logic [STEP_W-1:0]       step_size;
        logic signed [THR_W-1:0] power_delta_threshold;
        logic [VOLT_W-1:0]       voltage_ceiling;
        logic [VOLT_W-1:0]       voltage_floor;
    } cfg_t;

endpackage

FILE: hw/rtl/tpm_cfg.sv
// Configuration register file for the three-point MPPT tracker.
module tpm_cfg
    import tpm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_SIZE:       cfg_next.step_size = cfg_wdata[STEP_W-1:0];
                REG_DELTA_THRESHOLD: cfg_next.power_delta_threshold = $signed(cfg_wdata);
                REG_VOLTAGE_CEILING: cfg_next.voltage_ceiling = cfg_wdata[VOLT_W-1:0];
                REG_VOLTAGE_FLOOR:   cfg_next.voltage_floor = cfg_wdata[VOLT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size             <= STEP_SIZE_RST;
            cfg_reg.power_delta_threshold <= THRESHOLD_RST;
            cfg_reg.voltage_ceiling       <= CEILING_RST;
            cfg_reg.voltage_floor         <= FLOOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/tpm_track.sv
// Tracking datapath: three-point perturb-and-observe state and reference calculation.
module tpm_track
    import tpm_pkg::*;
#(
    parameter int WARMUP_STEPS = 8
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      track_fire,
    input  logic      restart_fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam int CNT_W = $clog2(WARMUP_STEPS + 1);
    localparam logic [CNT_W-1:0] WARMUP_LAST = CNT_W'(WARMUP_STEPS);

    // Phase codes: what the next tracking word does
    localparam logic [1:0] PH_STEP_UP   = 2'd0;
    localparam logic [1:0] PH_STEP_DOWN = 2'd1;
    localparam logic [1:0] PH_DECIDE    = 2'd2;

    localparam int PROD_W = VOLT_W + GAIN_W;

    logic [1:0]                phase_reg, phase_next;
    logic signed [2:0]         vote_reg, vote_next;
    logic [CNT_W-1:0]          warmup_reg, warmup_next;
    logic [POWER_W-1:0]        base_power_reg, base_power_next;
    logic [VOLT_W-1:0]         present_reg, present_next;
    logic signed [POINT_W-1:0] point_a_reg, point_a_next;
    logic signed [POINT_W-1:0] point_b_reg, point_b_next;
    logic signed [POINT_W-1:0] point_c_reg, point_c_next;

    logic signed [POWER_W+1:0] delta;
    logic signed [POWER_W+1:0] thr_ext;
    logic                      loss;
    logic signed [POINT_W-1:0] step_ext;
    logic signed [POINT_W-1:0] present_ext;
    logic signed [POINT_W-1:0] ceil_ext;
    logic signed [POINT_W-1:0] floor_ext;
    logic signed [2:0]         vote_up;
    logic signed [2:0]         vote_down;
    logic signed [2:0]         vote_decide;
    logic [PROD_W-1:0]         warm_prod;
    logic signed [POINT_W-1:0] warm_v;
    logic                      warm;
    logic signed [POINT_W-1:0] v;

    // Power change against the base and hysteresis compare
    assign delta   = $signed({2'b00, item.pv_power}) - $signed({2'b00, base_power_reg});
    assign thr_ext = $signed({cfg.power_delta_threshold[THR_W-1], cfg.power_delta_threshold});
    assign loss    = delta < thr_ext;

    assign step_ext    = $signed({{(POINT_W-STEP_W){1'b0}}, cfg.step_size});
    assign present_ext = $signed({{(POINT_W-VOLT_W){1'b0}}, present_reg});
    assign ceil_ext    = $signed({{(POINT_W-VOLT_W){1'b0}}, cfg.voltage_ceiling});
    assign floor_ext   = $signed({{(POINT_W-VOLT_W){1'b0}}, cfg.voltage_floor});

    assign vote_up     = vote_reg + 3'sd1;
    assign vote_down   = vote_reg - 3'sd1;
    assign vote_decide = loss ? vote_up : vote_down;

    // Warm-up reference: 0.98 * pv_voltage, truncated
    assign warm_prod = PROD_W'(item.pv_voltage) * PROD_W'(GAIN_098_Q15);
    assign warm_v    = $signed({{(POINT_W-VOLT_W){1'b0}}, warm_prod[PROD_W-1:GAIN_W]});
    assign warm      = warmup_reg < WARMUP_LAST;

    // Next state and reference for one tracking word
    always_comb
    begin
        phase_next      = phase_reg;
        vote_next       = vote_reg;
        warmup_next     = warmup_reg;
        base_power_next = base_power_reg;
        point_a_next    = point_a_reg;
        point_b_next    = point_b_reg;
        point_c_next    = point_c_reg;
        v               = present_ext;

        unique case (phase_reg)
            PH_STEP_UP:
            begin
                phase_next      = PH_STEP_DOWN;
                vote_next       = 3'sd0;
                base_power_next = item.pv_power;
                v               = present_ext + step_ext;
                point_c_next    = present_ext + step_ext;
            end
            PH_STEP_DOWN:
            begin
                phase_next   = PH_DECIDE;
                v            = present_ext - (step_ext <<< 1);
                point_a_next = present_ext - (step_ext <<< 1);
                vote_next    = loss ? vote_down : vote_up;
            end
            PH_DECIDE:
            begin
                phase_next = PH_STEP_UP;
                vote_next  = vote_decide;
                if (vote_decide == 3'sd2)
                    v = point_c_reg;
                else if (vote_decide == -3'sd2)
                    v = point_a_reg;
                else
                    v = point_b_reg;
                point_b_next = v;
            end
            default:
            begin
                phase_next = PH_STEP_UP;
            end
        endcase

        // Override during warm-up
        if (warm)
        begin
            v               = warm_v;
            point_b_next    = warm_v;
            base_power_next = item.pv_power;
            warmup_next     = warmup_reg + 1'b1;
            vote_next       = 3'sd0;
            phase_next      = PH_STEP_UP;
        end

        // Clamp: the ceiling is checked first; when the floor sits above it, values above the ceiling take the ceiling
        if (v > ceil_ext)
            present_next = cfg.voltage_ceiling;
        else if (v < floor_ext)
            present_next = cfg.voltage_floor;
        else
            present_next = v[VOLT_W-1:0];
    end

    assign result.voltage_reference = present_next;
    assign result.warming_up        = warm;

    // Advance state on each tracking word; a restart only drops the warm-up count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_STEP_UP;
            vote_reg       <= 3'sd0;
            warmup_reg     <= '0;
            base_power_reg <= '0;
            present_reg    <= '0;
            point_a_reg    <= '0;
            point_b_reg    <= '0;
            point_c_reg    <= '0;
        end
        else if (restart_fire)
        begin
            warmup_reg <= '0;
        end
        else if (track_fire)
        begin
            phase_reg      <= phase_next;
            vote_reg       <= vote_next;
            warmup_reg     <= warmup_next;
            base_power_reg <= base_power_next;
            present_reg    <= present_next;
            point_a_reg    <= point_a_next;
            point_b_reg    <= point_b_next;
            point_c_reg    <= point_c_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("phase reached unused code");

    a_vote_range: assert property (@(posedge clk) disable iff (!rst_n)
        vote_reg != 3'sd3 && vote_reg != -3'sd3 && vote_reg != -3'sd4)
        else $error("vote out of range");

    a_warmup_sat: assert property (@(posedge clk) disable iff (!rst_n)
        warmup_reg <= WARMUP_LAST)
        else $error("warm-up count past limit");

    a_warm_resets_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (track_fire && warm) |=> (phase_reg == PH_STEP_UP && vote_reg == 3'sd0))
        else $error("warm-up word left phase or vote set");
`endif

endmodule

FILE: hw/rtl/three_point_mppt_tracker.sv
// Top level of the three-point perturb-and-observe MPPT tracker.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one word per cycle:
//   while in_stall is low: a tracking word (kind 0) with filtered PV power
//   and voltage, or a restart word (kind 1) that clears the warm-up count
//   and produces no result. Output channel (out_valid / out_stall /
//   out_data) returns one word per tracking word: the clamped voltage
//   reference and the warm-up flag. Each tracking word passes the input
//   register, then the result register; the tracking state updates as the
//   result is loaded. Throughput: one word per cycle while out_stall does
//   not hold a waiting result.
//   Configuration: cfg_we / cfg_index / cfg_wdata write one register per edge;
//   write only while no word is in flight.
//   Reset: all tracking state clears, registers take their defaults, both
//   channels come up empty.
//   Stall: while out_stall holds a waiting result, the next tracking word
//   waits in the input register and in_stall rises; restart words still pass.
module three_point_mppt_tracker
    import tpm_pkg::*;
#(
    parameter int WARMUP_STEPS = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t      cfg;
    out_item_t result;

    logic      s1_valid_reg, s1_valid_next;
    in_item_t  s1_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_data_reg;

    logic      in_take;
    logic      out_free;
    logic      s1_fire;
    logic      track_fire;
    logic      restart_fire;

    tpm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tpm_track #(
        .WARMUP_STEPS (WARMUP_STEPS)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .track_fire   (track_fire),
        .restart_fire (restart_fire),
        .item         (s1_item_reg),
        .cfg          (cfg),
        .result       (result)
    );

    // Handshake: drain a tracking word when the result slot is free; a restart word always drains
    assign out_free     = !out_valid_reg || !out_stall;
    assign s1_fire      = s1_valid_reg && ((s1_item_reg.kind == KIND_RESTART) || out_free);
    assign track_fire   = s1_fire && (s1_item_reg.kind == KIND_TRACK);
    assign restart_fire = s1_fire && (s1_item_reg.kind == KIND_RESTART);
    assign in_stall     = s1_valid_reg && !s1_fire;
    assign in_take      = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_fire);
    assign out_valid_next = track_fire || (out_valid_reg && out_stall);

    // Hold valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_data;
        if (track_fire)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_track_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        track_fire |=> out_valid)
        else $error("tracking word produced no result");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !in_stall)
        else $error("input stalled with empty input register");

    a_restart_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (restart_fire && !out_valid_reg) |=> !out_valid)
        else $error("restart word produced a result");
`endif

endmodule
